### sv/eatf_pkg.sv
// Package: shared constants, types and helper functions for the Euler-angle transform builder.
`default_nettype none
package eatf_pkg;

	localparam int CordicSteps = 16;
	localparam int RotFracBits = 14;
	localparam int CdW = 34;

	localparam logic signed [CdW-1:0] GainQ30 = 34'sd652032874;
	localparam logic signed [CdW-1:0] PiQ30 = 34'sd3373259426;
	localparam logic signed [CdW-1:0] HalfPiQ30 = 34'sd1686629713;

	localparam logic [0:0] OpLocalToParent = 1'b0;
	localparam logic [0:0] OpParentToLocal = 1'b1;

	typedef logic signed [CdW-1:0] cd_t;

	typedef struct packed {
		logic        op;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} side_t;

	typedef struct packed {
		cd_t x;
		cd_t y;
		cd_t z;
		logic flip;
	} lane_t;

	function automatic cd_t atan_q30(input int i);
		cd_t r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = cd_t'(34'sd1 << (30 - i));
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/eatf_cell.sv
// CORDIC cell: one micro-rotation for the three angle lanes plus the side payload.
`default_nettype none
module eatf_cell
	import eatf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire  [4:0]  step,
	input  wire         en,
	input  wire         vld_in,
	input  lane_t [2:0] lane_in,
	input  side_t       side_in,
	output logic        vld_q,
	output lane_t [2:0] lane_q,
	output side_t       side_q
);
	lane_t [2:0] nxt;
	cd_t a;

	always_comb begin
		a = atan_q30(int'(step));
		for (int k = 0; k < 3; k++) begin
			nxt[k].flip = lane_in[k].flip;
			if (!lane_in[k].z[CdW-1]) begin
				nxt[k].x = lane_in[k].x - (lane_in[k].y >>> step);
				nxt[k].y = lane_in[k].y + (lane_in[k].x >>> step);
				nxt[k].z = lane_in[k].z - a;
			end else begin
				nxt[k].x = lane_in[k].x + (lane_in[k].y >>> step);
				nxt[k].y = lane_in[k].y - (lane_in[k].x >>> step);
				nxt[k].z = lane_in[k].z + a;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt;
			side_q <= side_in;
		end
	end
endmodule
`default_nettype wire

### sv/eatf_matrix.sv
// Matrix and translation back end: products, rounding, transpose and saturation.
`default_nettype none
module eatf_matrix
	import eatf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         en,
	input  wire         vld_in,
	input  lane_t [2:0] lane_in,
	input  side_t       side_in,
	output logic        vld_out,
	output logic [16*9-1:0] m_out,
	output logic [95:0] t_out
);
	typedef logic signed [63:0] w_t;
	localparam int Sh = 60 - RotFracBits;

	// Stage 1: sine/cosine after quadrant fold-back.
	cd_t sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	side_t sd_s1, sd_s2, sd_s3, sd_s4, sd_s5;
	logic [5:0] v_q;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= lane_in[0].flip ? -lane_in[0].y : lane_in[0].y;
			cx_s1 <= lane_in[0].flip ? -lane_in[0].x : lane_in[0].x;
			sy_s1 <= lane_in[1].flip ? -lane_in[1].y : lane_in[1].y;
			cy_s1 <= lane_in[1].flip ? -lane_in[1].x : lane_in[1].x;
			sz_s1 <= lane_in[2].flip ? -lane_in[2].y : lane_in[2].y;
			cz_s1 <= lane_in[2].flip ? -lane_in[2].x : lane_in[2].x;
			sd_s1 <= side_in;
		end
	end

	// Stage 2: inner products and pair products.
	w_t psx_s2, pcx_s2, p02_s2, p10_s2, p11_s2, p22_s2, cycz_s2, cysz_s2, sycz_s2, szsy_s2;
	cd_t sx_s2, sz_s2, cz_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			psx_s2 <= 64'(sy_s1) * 64'(sx_s1);
			pcx_s2 <= 64'(cy_s1) * 64'(sx_s1);
			p02_s2 <= 64'(sy_s1) * 64'(cx_s1);
			p10_s2 <= 64'(sz_s1) * 64'(cx_s1);
			p11_s2 <= 64'(cz_s1) * 64'(cx_s1);
			p22_s2 <= 64'(cy_s1) * 64'(cx_s1);
			cycz_s2 <= 64'(cy_s1) * 64'(cz_s1);
			cysz_s2 <= 64'(cy_s1) * 64'(sz_s1);
			sycz_s2 <= 64'(sy_s1) * 64'(cz_s1);
			szsy_s2 <= 64'(sz_s1) * 64'(sy_s1);
			sx_s2 <= sx_s1; sz_s2 <= sz_s1; cz_s2 <= cz_s1;
			sd_s2 <= sd_s1;
		end
	end

	// Stage 3: triple products from the rounded inner products.
	w_t rps, rpc;
	assign rps = (psx_s2 + 64'sd536870912) >>> 30;
	assign rpc = (pcx_s2 + 64'sd536870912) >>> 30;

	w_t e_s3 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			e_s3[0] <= cycz_s2 + 64'(sz_s2) * 64'(cd_t'(rps));
			e_s3[1] <= -cysz_s2 + 64'(cz_s2) * 64'(cd_t'(rps));
			e_s3[2] <= p02_s2;
			e_s3[3] <= p10_s2;
			e_s3[4] <= p11_s2;
			e_s3[5] <= -(64'(sx_s2) <<< 30);
			e_s3[6] <= -sycz_s2 + 64'(sz_s2) * 64'(cd_t'(rpc));
			e_s3[7] <= szsy_s2 + 64'(cz_s2) * 64'(cd_t'(rpc));
			e_s3[8] <= p22_s2;
			sd_s3 <= sd_s2;
		end
	end

	// Stage 4: round and clamp each entry, then transpose if required.
	function automatic logic signed [16:0] ent(input w_t v);
		w_t r;
		r = (v + (64'sd1 <<< (Sh - 1))) >>> Sh;
		if (r > (64'sd1 <<< RotFracBits)) r = 64'sd1 <<< RotFracBits;
		if (r < -(64'sd1 <<< RotFracBits)) r = -(64'sd1 <<< RotFracBits);
		return r[16:0];
	endfunction

	logic signed [16:0] m_s4 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++)
				m_s4[k] <= (sd_s3.op == OpParentToLocal) ?
					ent(e_s3[(k % 3) * 3 + k / 3]) : ent(e_s3[k]);
			sd_s4 <= sd_s3;
		end
	end

	// Stage 5: position times matrix entries.
	w_t q_s5 [9];
	logic signed [16:0] m_s5 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				q_s5[k] <= 64'($signed(k % 3 == 0 ? sd_s4.px : k % 3 == 1 ? sd_s4.py : sd_s4.pz))
					* 64'(m_s4[k]);
				m_s5[k] <= m_s4[k];
			end
			sd_s5 <= sd_s4;
		end
	end

	// Stage 6: for parent-to-local, sum, negate, round and saturate; else pass the position through.
	function automatic logic [31:0] tr(input w_t a);
		w_t r;
		r = (-a + (64'sd1 <<< (RotFracBits - 1))) >>> RotFracBits;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) m_out[16*k +: 16] <= m_s5[k][15:0];
			for (int r = 0; r < 3; r++) begin
				if (sd_s5.op == OpParentToLocal)
					t_out[32*r +: 32] <= tr(q_s5[3*r] + q_s5[3*r+1] + q_s5[3*r+2]);
				else
					t_out[32*r +: 32] <= r == 0 ? sd_s5.px : r == 1 ? sd_s5.py : sd_s5.pz;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[4:0], vld_in};
	end
	assign vld_out = v_q[5];
endmodule
`default_nettype wire

### sv/euler_angles_to_affine_transform.sv
// Top level: CORDIC cell chain feeding the matrix back end.
//  channel | dir | contents
//  s_axis  | in  | tuser opcode, tdata pos_x,pos_y,pos_z,angle_x,angle_y,angle_z
//  m_axis  | out | tdata m00..m22, tx, ty, tz
// One item per cycle while the output is not stalled; 16 CORDIC cells plus 6 back-end stages.
// The whole pipeline advances while the output register is empty or being taken,
// so a stalled result holds every stage. Reset clears the valid flags only.
`default_nettype none
module euler_angles_to_affine_transform
	import eatf_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [143:0] s_axis_tdata, // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z
	input  wire  [0:0]   s_axis_tuser, // opcode
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [239:0] m_axis_tdata  // m00..m22, tx, ty, tz
);
	logic en, vo;
	lane_t [2:0] l [CordicSteps+1];
	side_t s [CordicSteps+1];
	logic v [CordicSteps+1];
	logic [143:0] mo;
	logic [95:0] to;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cd_t a;
			a = cd_t'($signed(s_axis_tdata[96 + 16*k +: 16])) <<< 17;
			l[0][k].x = GainQ30;
			l[0][k].y = '0;
			l[0][k].flip = (a > HalfPiQ30) || (a < -HalfPiQ30);
			l[0][k].z = (a > HalfPiQ30) ? a - PiQ30 : (a < -HalfPiQ30) ? a + PiQ30 : a;
		end
		s[0].op = s_axis_tuser[0];
		s[0].px = s_axis_tdata[31:0];
		s[0].py = s_axis_tdata[63:32];
		s[0].pz = s_axis_tdata[95:64];
		v[0] = s_axis_tvalid;
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
		eatf_cell u_cell (
			.clk(clk), .arst_n(arst_n), .step(5'(i)), .en(en), .vld_in(v[i]),
			.lane_in(l[i]), .side_in(s[i]),
			.vld_q(v[i+1]), .lane_q(l[i+1]), .side_q(s[i+1])
		);
	end

	eatf_matrix u_mat (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v[CordicSteps]),
		.lane_in(l[CordicSteps]), .side_in(s[CordicSteps]),
		.vld_out(vo), .m_out(mo), .t_out(to)
	);

	assign m_axis_tvalid = vo;
	assign m_axis_tdata = {to, mo};
endmodule
`default_nettype wire
